// ===== sv/breath_cycle_timer_top_assert.svh =====
// Assertion macros for the breath-cycle timer blocks.
// Define ASSERT_OFF to compile the assertions out.
`ifndef BREATH_CYCLE_TIMER_TOP_ASSERT_SVH
`define BREATH_CYCLE_TIMER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define BCT_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("breath cycle timer assertion failed");
// Next-cycle implication, checked out of reset.
`define BCT_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("breath cycle timer assertion failed");
`else
`define BCT_ASSERT_IMP(name, clk, rstn, ante, cons)
`define BCT_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/bcyc_pkg.sv =====
// Shared types, constants and helpers for the breath-cycle timer.
// No dependencies; used by bcyc_div, bcyc_core and breath_cycle_timer_top.
package bcyc_pkg;

    localparam int DIV_W = 37;          // widest dividend: 20*duration + half the divisor
    localparam int DEN_W = 33;          // widest divisor: 2*duration
    localparam int REM_W = DEN_W + 1;
    localparam int CNT_W = 6;
    localparam int PROD_W = 24;

    typedef logic [DIV_W-1:0]  div_num_t;
    typedef logic [DEN_W-1:0]  div_den_t;
    typedef logic [CNT_W-1:0]  div_cnt_t;
    typedef logic [PROD_W-1:0] prod_t;

    // Quotient bits per division
    localparam div_cnt_t BITS_PERIOD = div_cnt_t'(16);
    localparam div_cnt_t BITS_HOLD   = div_cnt_t'(PROD_W);
    localparam div_cnt_t BITS_RATE   = div_cnt_t'(33);
    localparam div_cnt_t BITS_RATIO  = div_cnt_t'(DIV_W);
    localparam div_cnt_t CNT_ONE     = div_cnt_t'(1);

    localparam logic [15:0] MS_PER_MIN   = 16'd60000;
    localparam logic [32:0] MS_TWO_MIN   = 33'd120000;
    localparam logic [7:0]  RATE_MAX     = 8'd255;
    localparam logic [9:0]  IE_MAX       = 10'd999;
    localparam logic [9:0]  IE_UNIT      = 10'd10;

    typedef enum logic [2:0] {
        MODE_SAMPLE    = 3'd0,
        MODE_START     = 3'd1,
        MODE_MARK_INSP = 3'd2,
        MODE_MARK_EXP  = 3'd3,
        MODE_CLOSE     = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        CFG_BPM     = 3'd0,
        CFG_IE_INSP = 3'd1,
        CFG_IE_EXP  = 3'd2,
        CFG_PLATEAU = 3'd3,
        CFG_PEEP    = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PER_WAIT,
        ST_HOLD_MUL,
        ST_HOLD_GO,
        ST_HOLD_WAIT,
        ST_START_FIN,
        ST_RATE_WAIT,
        ST_RATIO_GO,
        ST_RATIO_WAIT,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic [31:0]        now_ms;
        logic signed [15:0] pressure;
    } in_item_t;

    typedef struct packed {
        logic        inspiration_done;
        logic        hold_done;
        logic        expiration_done;
        logic        peep_pause_done;
        logic        timing_error;
        logic [14:0] running_peak;
        logic [14:0] breath_peak;
        logic [7:0]  measured_rate;
        logic [9:0]  measured_ie_insp;
        logic [9:0]  measured_ie_exp;
    } res_item_t;

    typedef struct packed {
        logic [5:0]  breaths_per_minute;
        logic [6:0]  ie_insp_tenths;
        logic [6:0]  ie_exp_tenths;
        logic [15:0] plateau_ms;
        logic [15:0] peep_pause_ms;
    } cfg_regs_t;

    typedef struct packed {
        logic     start;
        div_num_t num;      // left aligned: first quotient bit comes from the MSB
        div_den_t den;
        div_cnt_t count;
    } div_req_t;

    typedef struct packed {
        logic     busy;
        logic     done;
        div_num_t quot;
    } div_rsp_t;

    // Left-align a dividend of nbits significant bits
    function automatic div_num_t align_num(input div_num_t x, input div_cnt_t nbits);
        return x << (DIV_W - int'(nbits));
    endfunction

    function automatic logic [7:0] sat_rate(input div_num_t q);
        if (q > div_num_t'(RATE_MAX)) return RATE_MAX;
        return q[7:0];
    endfunction

    function automatic logic [9:0] sat_ie(input div_num_t q);
        if (q > div_num_t'(IE_MAX)) return IE_MAX;
        return q[9:0];
    endfunction

endpackage

// ===== sv/bcyc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on bcyc_pkg and breath_cycle_timer_top_assert.svh.
`include "breath_cycle_timer_top_assert.svh"

module bcyc_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  bcyc_pkg::div_req_t  req,
    output bcyc_pkg::div_rsp_t  rsp
);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    bcyc_pkg::div_cnt_t        cnt_reg, cnt_next;
    bcyc_pkg::div_num_t        num_reg, num_next;
    bcyc_pkg::div_num_t        quot_reg, quot_next;
    bcyc_pkg::div_den_t        den_reg, den_next;
    logic [bcyc_pkg::REM_W-1:0] rem_reg, rem_next;

    logic [bcyc_pkg::REM_W-1:0] rem_shift;
    logic [bcyc_pkg::REM_W:0]   diff;
    logic                       ge;

    assign rem_shift = {rem_reg[bcyc_pkg::REM_W-2:0], num_reg[bcyc_pkg::DIV_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};
    assign ge        = ~diff[bcyc_pkg::REM_W];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.count;
            num_next  = req.num;
            den_next  = req.den;
            quot_next = '0;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[bcyc_pkg::REM_W-1:0] : rem_shift;
            quot_next = {quot_reg[bcyc_pkg::DIV_W-2:0], ge};
            num_next  = {num_reg[bcyc_pkg::DIV_W-2:0], 1'b0};
            cnt_next  = cnt_reg - bcyc_pkg::CNT_ONE;
            if (cnt_reg == bcyc_pkg::CNT_ONE) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    `BCT_ASSERT_IMP(a_no_restart, aclk, aresetn, req.start, !busy_reg)
    `BCT_ASSERT_IMP(a_count_nonzero, aclk, aresetn, req.start, req.count != '0)
    `BCT_ASSERT_NXT(a_last_step, aclk, aresetn, busy_reg && cnt_reg == bcyc_pkg::CNT_ONE, done_reg && !busy_reg)
    `BCT_ASSERT_IMP(a_done_idle, aclk, aresetn, done_reg, !busy_reg)

endmodule

// ===== sv/bcyc_core.sv =====
// Breath-cycle state, event sequencer and result assembly.
// Depends on bcyc_pkg, bcyc_div and breath_cycle_timer_top_assert.svh.
`include "breath_cycle_timer_top_assert.svh"

module bcyc_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  bcyc_pkg::in_item_t   item,
    input  bcyc_pkg::cfg_regs_t  cfg,
    output logic                 idle,
    output logic                 res_valid,
    input  logic                 res_ready,
    output bcyc_pkg::res_item_t  res
);

    bcyc_pkg::seq_state_t state_reg, state_next;
    bcyc_pkg::in_item_t   item_reg;

    logic [31:0]        cycle_start_reg, cycle_start_next;
    logic [16:0]        period_len_reg, period_len_next;
    logic [16:0]        insp_hold_len_reg, insp_hold_len_next;
    logic signed [17:0] insp_len_reg, insp_len_next;
    logic signed [17:0] exp_len_reg, exp_len_next;
    logic               error_flag_reg, error_flag_next;
    logic [31:0]        insp_dur_reg, insp_dur_next;
    logic [31:0]        exp_dur_reg, exp_dur_next;
    logic [15:0]        peak_now_reg, peak_now_next;
    logic [15:0]        peak_latched_reg, peak_latched_next;
    logic [7:0]         rate_held_reg, rate_held_next;
    logic [9:0]         ie_insp_held_reg, ie_insp_held_next;
    logic [9:0]         ie_exp_held_reg, ie_exp_held_next;

    bcyc_pkg::prod_t    prod_reg, prod_next;
    logic [31:0]        rnum_reg, rnum_next;
    logic [31:0]        rden_reg, rden_next;
    logic               rswap_reg, rswap_next;
    logic               rzero_reg, rzero_next;

    bcyc_pkg::div_req_t div_req;
    bcyc_pkg::div_rsp_t div_rsp;

    logic [7:0]         ratio_sum;
    logic [31:0]        since_start;
    logic [32:0]        rate_num;
    logic [31:0]        elapsed;
    logic signed [33:0] el_s;
    logic signed [18:0] peep_lim;
    logic               in_wait;

    bcyc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign ratio_sum   = {1'b0, cfg.ie_insp_tenths} + {1'b0, cfg.ie_exp_tenths};
    assign since_start = item_reg.now_ms - cycle_start_reg;
    assign rate_num    = {1'b0, since_start} + bcyc_pkg::MS_TWO_MIN;
    assign elapsed     = since_start;
    assign el_s        = $signed({2'b00, elapsed});
    assign peep_lim    = $signed({exp_len_reg[17], exp_len_reg})
                       + $signed({3'b000, cfg.peep_pause_ms});
    assign idle        = (state_reg == bcyc_pkg::ST_IDLE);

    always_comb begin
        state_next         = state_reg;
        cycle_start_next   = cycle_start_reg;
        period_len_next    = period_len_reg;
        insp_hold_len_next = insp_hold_len_reg;
        insp_len_next      = insp_len_reg;
        exp_len_next       = exp_len_reg;
        error_flag_next    = error_flag_reg;
        insp_dur_next      = insp_dur_reg;
        exp_dur_next       = exp_dur_reg;
        peak_now_next      = peak_now_reg;
        peak_latched_next  = peak_latched_reg;
        rate_held_next     = rate_held_reg;
        ie_insp_held_next  = ie_insp_held_reg;
        ie_exp_held_next   = ie_exp_held_reg;
        prod_next          = prod_reg;
        rnum_next          = rnum_reg;
        rden_next          = rden_reg;
        rswap_next         = rswap_reg;
        rzero_next         = rzero_reg;
        div_req            = '0;
        res_valid          = 1'b0;

        unique case (state_reg)
            bcyc_pkg::ST_IDLE: begin
                if (item_valid) state_next = bcyc_pkg::ST_DECODE;
            end
            bcyc_pkg::ST_DECODE: begin
                state_next = bcyc_pkg::ST_EMIT;
                unique case (item_reg.mode)
                    bcyc_pkg::MODE_SAMPLE: begin
                        if (item_reg.pressure > $signed({1'b0, peak_now_reg}))
                            peak_now_next = item_reg.pressure;
                    end
                    bcyc_pkg::MODE_START: begin
                        cycle_start_next = item_reg.now_ms;
                        div_req.start = 1'b1;
                        div_req.num   = bcyc_pkg::align_num(
                            bcyc_pkg::div_num_t'(bcyc_pkg::MS_PER_MIN), bcyc_pkg::BITS_PERIOD);
                        div_req.den   = bcyc_pkg::div_den_t'(cfg.breaths_per_minute);
                        div_req.count = bcyc_pkg::BITS_PERIOD;
                        state_next    = bcyc_pkg::ST_PER_WAIT;
                    end
                    bcyc_pkg::MODE_MARK_INSP: begin
                        insp_dur_next = since_start;
                    end
                    bcyc_pkg::MODE_MARK_EXP: begin
                        exp_dur_next = since_start - insp_dur_reg;
                    end
                    bcyc_pkg::MODE_CLOSE: begin
                        div_req.start = 1'b1;
                        div_req.num   = bcyc_pkg::align_num(
                            bcyc_pkg::div_num_t'(rate_num), bcyc_pkg::BITS_RATE);
                        div_req.den   = {since_start, 1'b0};
                        div_req.count = bcyc_pkg::BITS_RATE;
                        rswap_next    = exp_dur_reg > insp_dur_reg;
                        rzero_next    = (exp_dur_reg == '0) && (insp_dur_reg == '0);
                        rnum_next     = (exp_dur_reg > insp_dur_reg) ? exp_dur_reg : insp_dur_reg;
                        rden_next     = (exp_dur_reg > insp_dur_reg) ? insp_dur_reg : exp_dur_reg;
                        peak_latched_next = peak_now_reg;
                        peak_now_next     = '0;
                        state_next        = bcyc_pkg::ST_RATE_WAIT;
                    end
                    default: begin
                    end
                endcase
            end
            bcyc_pkg::ST_PER_WAIT: begin
                if (div_rsp.done) begin
                    period_len_next = (cfg.breaths_per_minute == '0) ? '0 : div_rsp.quot[16:0];
                    state_next      = bcyc_pkg::ST_HOLD_MUL;
                end
            end
            bcyc_pkg::ST_HOLD_MUL: begin
                prod_next  = bcyc_pkg::prod_t'(cfg.ie_insp_tenths)
                           * bcyc_pkg::prod_t'(period_len_reg);
                state_next = bcyc_pkg::ST_HOLD_GO;
            end
            bcyc_pkg::ST_HOLD_GO: begin
                div_req.start = 1'b1;
                div_req.num   = bcyc_pkg::align_num(
                    bcyc_pkg::div_num_t'(prod_reg), bcyc_pkg::BITS_HOLD);
                div_req.den   = bcyc_pkg::div_den_t'(ratio_sum);
                div_req.count = bcyc_pkg::BITS_HOLD;
                state_next    = bcyc_pkg::ST_HOLD_WAIT;
            end
            bcyc_pkg::ST_HOLD_WAIT: begin
                if (div_rsp.done) begin
                    insp_hold_len_next = (ratio_sum == '0) ? '0 : div_rsp.quot[16:0];
                    state_next         = bcyc_pkg::ST_START_FIN;
                end
            end
            bcyc_pkg::ST_START_FIN: begin
                insp_len_next   = $signed({1'b0, insp_hold_len_reg})
                                - $signed({2'b00, cfg.plateau_ms});
                exp_len_next    = $signed({1'b0, period_len_reg})
                                - $signed({1'b0, insp_hold_len_reg});
                error_flag_next = insp_len_next[17] | exp_len_next[17];
                state_next      = bcyc_pkg::ST_EMIT;
            end
            bcyc_pkg::ST_RATE_WAIT: begin
                if (div_rsp.done) begin
                    rate_held_next = bcyc_pkg::sat_rate(div_rsp.quot);
                    state_next     = bcyc_pkg::ST_RATIO_GO;
                end
            end
            bcyc_pkg::ST_RATIO_GO: begin
                if (rzero_reg) begin
                    ie_insp_held_next = bcyc_pkg::IE_UNIT;
                    ie_exp_held_next  = bcyc_pkg::IE_UNIT;
                    state_next        = bcyc_pkg::ST_EMIT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = bcyc_pkg::div_num_t'({rnum_reg, 4'b0000})
                                  + bcyc_pkg::div_num_t'({rnum_reg, 2'b00})
                                  + bcyc_pkg::div_num_t'(rden_reg);
                    div_req.den   = {rden_reg, 1'b0};
                    div_req.count = bcyc_pkg::BITS_RATIO;
                    state_next    = bcyc_pkg::ST_RATIO_WAIT;
                end
            end
            bcyc_pkg::ST_RATIO_WAIT: begin
                if (div_rsp.done) begin
                    if (rswap_reg) begin
                        ie_insp_held_next = bcyc_pkg::IE_UNIT;
                        ie_exp_held_next  = bcyc_pkg::sat_ie(div_rsp.quot);
                    end else begin
                        ie_exp_held_next  = bcyc_pkg::IE_UNIT;
                        ie_insp_held_next = bcyc_pkg::sat_ie(div_rsp.quot);
                    end
                    state_next = bcyc_pkg::ST_EMIT;
                end
            end
            bcyc_pkg::ST_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) state_next = bcyc_pkg::ST_IDLE;
            end
            default: begin
                state_next = bcyc_pkg::ST_IDLE;
            end
        endcase
    end

    // Result fields reflect the state after the event
    always_comb begin
        res.inspiration_done = el_s > $signed({{16{insp_len_reg[17]}}, insp_len_reg});
        res.hold_done        = elapsed > {15'd0, insp_hold_len_reg};
        res.expiration_done  = elapsed > {15'd0, period_len_reg};
        res.peep_pause_done  = el_s > $signed({{15{peep_lim[18]}}, peep_lim});
        res.timing_error     = error_flag_reg;
        res.running_peak     = peak_now_reg[14:0];
        res.breath_peak      = peak_latched_reg[14:0];
        res.measured_rate    = rate_held_reg;
        res.measured_ie_insp = ie_insp_held_reg;
        res.measured_ie_exp  = ie_exp_held_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= bcyc_pkg::ST_IDLE;
            cycle_start_reg   <= '0;
            period_len_reg    <= '0;
            insp_hold_len_reg <= '0;
            insp_len_reg      <= '0;
            exp_len_reg       <= '0;
            error_flag_reg    <= 1'b0;
            insp_dur_reg      <= '0;
            exp_dur_reg       <= '0;
            peak_now_reg      <= '0;
            peak_latched_reg  <= '0;
            rate_held_reg     <= '0;
            ie_insp_held_reg  <= '0;
            ie_exp_held_reg   <= '0;
        end else begin
            state_reg         <= state_next;
            cycle_start_reg   <= cycle_start_next;
            period_len_reg    <= period_len_next;
            insp_hold_len_reg <= insp_hold_len_next;
            insp_len_reg      <= insp_len_next;
            exp_len_reg       <= exp_len_next;
            error_flag_reg    <= error_flag_next;
            insp_dur_reg      <= insp_dur_next;
            exp_dur_reg       <= exp_dur_next;
            peak_now_reg      <= peak_now_next;
            peak_latched_reg  <= peak_latched_next;
            rate_held_reg     <= rate_held_next;
            ie_insp_held_reg  <= ie_insp_held_next;
            ie_exp_held_reg   <= ie_exp_held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (idle && item_valid) item_reg <= item;
        prod_reg  <= prod_next;
        rnum_reg  <= rnum_next;
        rden_reg  <= rden_next;
        rswap_reg <= rswap_next;
        rzero_reg <= rzero_next;
    end

    assign in_wait = (state_reg == bcyc_pkg::ST_PER_WAIT)
                  || (state_reg == bcyc_pkg::ST_HOLD_WAIT)
                  || (state_reg == bcyc_pkg::ST_RATE_WAIT)
                  || (state_reg == bcyc_pkg::ST_RATIO_WAIT);

    `BCT_ASSERT_IMP(a_done_in_wait, aclk, aresetn, div_rsp.done, in_wait)
    `BCT_ASSERT_IMP(a_exp_nonneg, aclk, aresetn, 1'b1, !exp_len_reg[17])
    `BCT_ASSERT_IMP(a_peak_nonneg, aclk, aresetn, 1'b1, !peak_now_reg[15] && !peak_latched_reg[15])
    `BCT_ASSERT_IMP(a_err_match, aclk, aresetn, res_valid, error_flag_reg == (insp_len_reg[17] | exp_len_reg[17]))

endmodule

// ===== sv/breath_cycle_timer_top.sv =====
// Breath-cycle timer top: configuration registers, request and result handshakes.
// Sample, mark and unused modes go straight from decode to the result; start cycle
// runs the period and then the hold division; close breath runs the rate and then the
// ratio division, skipping the ratio when both phase durations are zero. One request
// at a time: with m_ready high the next request can be taken in the same cycle that m_valid rises.
// Reset (aresetn low, synchronous) clears all breath state and loads the register defaults.
module breath_cycle_timer_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bcyc_pkg::in_item_t   s_data,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output bcyc_pkg::res_item_t  m_data,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_wdata
);

    bcyc_pkg::cfg_regs_t  cfg_reg, cfg_next;
    logic                 m_valid_reg, m_valid_next;
    bcyc_pkg::res_item_t  m_data_reg;

    logic                 core_idle;
    logic                 res_valid;
    logic                 res_ready;
    bcyc_pkg::res_item_t  res;

    // Configuration writes are registered; the register file never stalls.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                bcyc_pkg::CFG_BPM:     cfg_next.breaths_per_minute = cfg_wdata[5:0];
                bcyc_pkg::CFG_IE_INSP: cfg_next.ie_insp_tenths     = cfg_wdata[6:0];
                bcyc_pkg::CFG_IE_EXP:  cfg_next.ie_exp_tenths      = cfg_wdata[6:0];
                bcyc_pkg::CFG_PLATEAU: cfg_next.plateau_ms         = cfg_wdata;
                bcyc_pkg::CFG_PEEP:    cfg_next.peep_pause_ms      = cfg_wdata;
                default: begin
                    // drop writes to indexes outside the register list
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.breaths_per_minute <= 6'd12;
            cfg_reg.ie_insp_tenths     <= 7'd10;
            cfg_reg.ie_exp_tenths      <= 7'd20;
            cfg_reg.plateau_ms         <= 16'd0;
            cfg_reg.peep_pause_ms      <= 16'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Take a new request whenever the sequencer is idle, even with a result
    // still parked in the output register.
    assign s_ready = core_idle;

    bcyc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_valid),
        .item       (s_data),
        .cfg        (cfg_reg),
        .idle       (core_idle),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: advance the core's result when the slot is empty or
    // being emptied this cycle; otherwise hold it and stall the core.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) m_valid_next = 1'b1;
        else if (m_ready)           m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else          m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) m_data_reg <= res;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
